@@ sv/ssr_pkg.sv @@
// Shared constants for the streaming substring replace block.
package ssr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int PACK_BYTES = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

endpackage

@@ sv/ssr_in_if.sv @@
// Input text stream channel: one text byte and its end-of-text mark.
interface ssr_in_if;
  logic                         valid;
  logic                         ready;
  logic [ssr_pkg::BYTE_W-1:0]   text_byte;
  logic                         end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ sv/ssr_out_if.sv @@
// Output text stream channel: one result byte with its marks.
interface ssr_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssr_pkg::BYTE_W-1:0]   out_byte;
  logic                         byte_valid;
  logic                         run_last;
  logic                         text_done;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output text_done, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input text_done, output ready);
endinterface

@@ sv/stream_substring_replace.sv @@
// Streaming substring replace: window compare, burst buffer and output register.
// Results of an accepted byte pass from the burst buffer into the output register.
// Throughput: one byte per cycle while each byte yields at most one result. A byte
// that yields more keeps the input stalled until its last result is loaded, since
// the burst buffer drains one result per cycle into the single output register.
// Output stalls add to this.
// Reset (rst, synchronous): window empty, no pending results, registers at defaults.
module stream_substring_replace #(
  parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = ssr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  ssr_in_if.sink                            in_ch,
  ssr_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LEN_W = ssr_pkg::LEN_W;
  localparam int BYTE_W = ssr_pkg::BYTE_W;
  localparam int WIN_DEPTH = (MAX_PATTERN < ssr_pkg::PACK_BYTES) ?
                             MAX_PATTERN : ssr_pkg::PACK_BYTES;
  localparam int REP_DEPTH = (MAX_REPLACEMENT < ssr_pkg::PACK_BYTES) ?
                             MAX_REPLACEMENT : ssr_pkg::PACK_BYTES;
  localparam int BUF_DEPTH = (WIN_DEPTH > REP_DEPTH) ? WIN_DEPTH : REP_DEPTH;
  localparam int FILL_W = $clog2(WIN_DEPTH + 1);
  localparam int RCNT_W = $clog2(REP_DEPTH + 1);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int WIN_W = WIN_DEPTH * BYTE_W;
  localparam int REP_W = REP_DEPTH * BYTE_W;
  localparam int BUF_W = BUF_DEPTH * BYTE_W;

  // Configuration registers
  logic [WIN_W-1:0]  pat_reg;
  logic [LEN_W-1:0]  plen_reg;
  logic [REP_W-1:0]  rep_reg;
  logic [LEN_W-1:0]  rlen_reg;

  // Window and burst state
  logic [WIN_W-1:0]  win;
  logic [FILL_W-1:0] fill;
  logic [BUF_W-1:0]  burst_data;
  logic [CNT_W-1:0]  burst_cnt;
  logic              burst_end;
  logic              burst_bare;

  // Output register
  logic              o_valid;
  logic [BYTE_W-1:0] o_byte;
  logic              o_byte_valid;
  logic              o_run_last;
  logic              o_done;

  logic [FILL_W-1:0] plen;
  logic [RCNT_W-1:0] rlen;
  logic [FILL_W-1:0] f_eff;
  logic [FILL_W-1:0] nf;
  logic [WIN_W-1:0]  w_ins;
  logic              cmp;
  logic              match;
  logic [WIN_W-1:0]  win_next;
  logic [FILL_W-1:0] fill_next;
  logic [CNT_W-1:0]  load_cnt;
  logic              load_bare;
  logic [BUF_W-1:0]  load_data;
  logic              in_fire;
  logic              out_load;
  logic              in_ready;

  always_comb begin
    if (plen_reg == '0) begin
      plen = FILL_W'(1);
    end else if (plen_reg > LEN_W'(WIN_DEPTH)) begin
      plen = FILL_W'(WIN_DEPTH);
    end else begin
      plen = FILL_W'(plen_reg);
    end
    if (rlen_reg > LEN_W'(REP_DEPTH)) begin
      rlen = RCNT_W'(REP_DEPTH);
    end else begin
      rlen = RCNT_W'(rlen_reg);
    end
  end

  // Insert the new byte at the fill position and compare when the window is full.
  always_comb begin
    f_eff = (fill >= plen) ? '0 : fill;
    nf = f_eff + FILL_W'(1);
    match = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w_ins[i*BYTE_W +: BYTE_W] = (FILL_W'(i) == f_eff) ? in_ch.text_byte
                                                         : win[i*BYTE_W +: BYTE_W];
    end
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((FILL_W'(i) < plen) &&
          (w_ins[i*BYTE_W +: BYTE_W] != pat_reg[i*BYTE_W +: BYTE_W])) begin
        match = 1'b0;
      end
    end
    cmp = (nf == plen);
  end

  // Decide what this byte emits and what the window keeps.
  always_comb begin
    win_next = w_ins;
    fill_next = nf;
    load_cnt = '0;
    if (cmp && match) begin
      load_cnt = CNT_W'(rlen);
      fill_next = '0;
    end else if (cmp) begin
      win_next = w_ins >> BYTE_W;
      load_cnt = in_ch.end_of_text ? CNT_W'(plen) : CNT_W'(1);
      fill_next = plen - FILL_W'(1);
    end else if (in_ch.end_of_text) begin
      load_cnt = CNT_W'(nf);
    end
    if (in_ch.end_of_text) begin
      fill_next = '0;
    end
    // A text that ends with nothing to emit still gets one bare end marker.
    load_bare = in_ch.end_of_text && (load_cnt == '0);
    if (load_bare) begin
      load_cnt = CNT_W'(1);
    end
    load_data = (cmp && match) ? BUF_W'(rep_reg) : BUF_W'(w_ins);
  end

  assign out_load = (burst_cnt != '0) && (!o_valid || out_ch.ready);
  assign in_ready = (burst_cnt == '0) || ((burst_cnt == CNT_W'(1)) && out_load);
  assign in_fire = in_ch.valid && in_ready;

  assign in_ch.ready = in_ready;
  assign out_ch.valid = o_valid;
  assign out_ch.out_byte = o_byte;
  assign out_ch.byte_valid = o_byte_valid;
  assign out_ch.run_last = o_run_last;
  assign out_ch.text_done = o_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_reg <= '0;
      plen_reg <= LEN_W'(1);
      rep_reg <= '0;
      rlen_reg <= '0;
      fill <= '0;
      burst_cnt <= '0;
      burst_end <= 1'b0;
      burst_bare <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == ssr_pkg::REG_PATTERN_LENGTH)) begin
        // A new pattern length drops any pending window bytes.
        fill <= '0;
      end else if (in_fire) begin
        fill <= fill_next;
      end
      if (in_fire) begin
        burst_cnt <= load_cnt;
        burst_end <= in_ch.end_of_text;
        burst_bare <= load_bare;
      end else if (out_load) begin
        burst_cnt <= burst_cnt - CNT_W'(1);
      end
      if (out_load) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          ssr_pkg::REG_PATTERN_BYTES: begin
            pat_reg <= cfg_data[WIN_W-1:0];
          end
          ssr_pkg::REG_PATTERN_LENGTH: begin
            plen_reg <= cfg_data[LEN_W-1:0];
          end
          ssr_pkg::REG_REPLACEMENT_BYTES: begin
            rep_reg <= cfg_data[REP_W-1:0];
          end
          ssr_pkg::REG_REPLACEMENT_LENGTH: begin
            rlen_reg <= cfg_data[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win <= win_next;
      burst_data <= load_data;
    end else if (out_load) begin
      burst_data <= burst_data >> BYTE_W;
    end
    if (out_load) begin
      o_byte <= burst_bare ? '0 : burst_data[BYTE_W-1:0];
      o_byte_valid <= !burst_bare;
      o_run_last <= (burst_cnt == CNT_W'(1));
      o_done <= (burst_cnt == CNT_W'(1)) && burst_end;
    end
  end

endmodule

@@ tb/tb_stream_substring_replace.sv @@
// Self-checking testbench for the streaming substring replace block.
module tb_stream_substring_replace;

  localparam int BYTE_W = ssr_pkg::BYTE_W;
  localparam int LEN_W = ssr_pkg::LEN_W;
  localparam int CFG_DATA_W = ssr_pkg::CFG_DATA_W;
  localparam int CFG_INDEX_W = ssr_pkg::CFG_INDEX_W;
  localparam int PACK_BYTES = ssr_pkg::PACK_BYTES;
  localparam int MAX_PATTERN_DEF = ssr_pkg::MAX_PATTERN_DEF;
  localparam int MAX_REPLACEMENT_DEF = ssr_pkg::MAX_REPLACEMENT_DEF;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DIRECTED_ITEMS = 23;
  localparam int RANDOM_ITEMS = 280;
  localparam int LATENCY_WAIT = 8;
  localparam int LONG_HOLD = 200;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              text_done;
  } out_item_t;

  // Predicts the output text and checks every output transaction against it.
  class replace_scoreboard;
    logic [CFG_DATA_W-1:0] pat_bytes;
    logic [LEN_W-1:0]      pat_len;
    logic [CFG_DATA_W-1:0] rep_bytes;
    logic [LEN_W-1:0]      rep_len;
    logic [BYTE_W-1:0]     window [PACK_BYTES];
    int unsigned           fill;
    out_item_t             expected_out [$];
    int                    errors;

    function void clear();
      pat_bytes = '0;
      pat_len = 4'd1;
      rep_bytes = '0;
      rep_len = 4'd0;
      for (int i = 0; i < PACK_BYTES; i++) window[i] = '0;
      fill = 0;
      expected_out.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        ssr_pkg::REG_PATTERN_BYTES: pat_bytes = data;
        ssr_pkg::REG_PATTERN_LENGTH: begin
          pat_len = data[LEN_W-1:0];
          fill = 0;
        end
        ssr_pkg::REG_REPLACEMENT_BYTES: rep_bytes = data;
        ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_out(logic [BYTE_W-1:0] b, logic v);
      out_item_t r;
      r.out_byte = b;
      r.byte_valid = v;
      r.run_last = 1'b0;
      r.text_done = 1'b0;
      expected_out.push_back(r);
    endfunction

    function void note_text_byte(logic [BYTE_W-1:0] b, logic eot);
      int unsigned plen;
      int unsigned rlen;
      int          first;
      bit          hit;
      plen = (pat_len == 0) ? 1 : ((pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len);
      rlen = (rep_len > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : rep_len;
      first = expected_out.size();
      if (fill >= plen) fill = 0;
      window[fill] = b;
      fill++;
      if (fill == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++) push_out(rep_bytes[8*i +: 8], 1'b1);
          fill = 0;
        end else begin
          push_out(window[0], 1'b1);
          for (int i = 1; i < plen; i++) window[i-1] = window[i];
          fill = plen - 1;
        end
      end
      if (eot) begin
        for (int i = 0; i < fill; i++) push_out(window[i], 1'b1);
        fill = 0;
        // With nothing left to emit, the end of text still gets a bare marker.
        if (expected_out.size() == first) push_out('0, 1'b0);
        expected_out[$].text_done = 1'b1;
      end
      if (expected_out.size() > first) expected_out[$].run_last = 1'b1;
    endfunction

    function void check_out_byte(out_item_t got);
      out_item_t exp;
      if (expected_out.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected output: out_byte=%h byte_valid=%b run_last=%b text_done=%b",
                   got.out_byte, got.byte_valid, got.run_last, got.text_done);
        return;
      end
      exp = expected_out.pop_front();
      if (got.out_byte !== exp.out_byte || got.byte_valid !== exp.byte_valid ||
          got.run_last !== exp.run_last || got.text_done !== exp.text_done) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                   exp.out_byte, exp.byte_valid, exp.run_last, exp.text_done,
                   got.out_byte, got.byte_valid, got.run_last, got.text_done);
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ssr_in_if in_ch ();
  ssr_out_if out_ch ();

  stream_substring_replace DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  replace_scoreboard sb;
  int cycle_count = 0;
  int items_sent = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  logic [CFG_DATA_W-1:0] cur_pat_bytes;
  int cur_plen;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[stream_substring_replace] ERROR");
      $finish;
    end
  end

  // Inputs are noted before outputs are checked; a result never shares its input's edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_text_byte(in_ch.text_byte, in_ch.end_of_text);
      if (out_ch.valid && out_ch.ready)
        sb.check_out_byte({out_ch.out_byte, out_ch.byte_valid, out_ch.run_last,
                           out_ch.text_done});
    end
  end

  // Output side: a random stall before each transaction, or one long hold-off on request.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic eot);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
  endtask

  // Lets the last accepted byte be noted, then waits for all output to drain.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] pb, input logic [CFG_DATA_W-1:0] pl,
                           input logic [CFG_DATA_W-1:0] rb, input logic [CFG_DATA_W-1:0] rl);
    write_reg(ssr_pkg::REG_PATTERN_BYTES, pb);
    write_reg(ssr_pkg::REG_PATTERN_LENGTH, pl);
    write_reg(ssr_pkg::REG_REPLACEMENT_BYTES, rb);
    write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, rl);
    cfg_we <= 1'b0;
    cur_pat_bytes = pb;
    cur_plen = (pl[LEN_W-1:0] == 0) ? 1 :
               ((pl[LEN_W-1:0] > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pl[LEN_W-1:0]));
  endtask

  // Structured text mixes whole and partial pattern copies with noise; else all noise.
  task automatic send_stream(input int count, input bit structured, input bit alpha);
    logic [BYTE_W-1:0] text [$];
    int piece;
    int cut;
    bit finish;
    logic [BYTE_W-1:0] noise;
    finish = ($urandom_range(0, 3) != 0);
    while (text.size() < count) begin
      piece = $urandom_range(0, 9);
      if (structured && piece < 5) begin
        for (int k = 0; k < cur_plen; k++) text.push_back(cur_pat_bytes[8*k +: 8]);
      end else if (structured && piece < 7) begin
        cut = $urandom_range(1, cur_plen);
        for (int k = 0; k < cut; k++) text.push_back(cur_pat_bytes[8*k +: 8]);
      end else begin
        noise = BYTE_W'($urandom_range(0, 255));
        if (alpha) begin
          case ($urandom_range(0, 2))
            0: noise = 8'h41;
            1: noise = 8'h42;
            default: ;
          endcase
        end
        text.push_back(noise);
      end
    end
    for (int k = 0; k < text.size(); k++)
      send_item(text[k], (finish && k == text.size() - 1) || ($urandom_range(0, 15) == 0));
  endtask

  initial begin
    int phase;
    bit alpha;
    logic [CFG_DATA_W-1:0] pb;
    logic [CFG_DATA_W-1:0] pl;
    logic [CFG_DATA_W-1:0] rl;
    sb = new;
    sb.clear();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.end_of_text = 1'b0;
    cur_pat_bytes = '0;
    cur_plen = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Defaults delete every zero byte, so a lone zero at end of text leaves a bare marker.
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    wait_idle();

    configure(64'h6261, 64'd2, 64'h5A5958, 64'd3);
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b1);
    // This byte stays pending and is dropped when the pattern length is rewritten.
    send_item(8'h61, 1'b0);
    wait_idle();

    configure({8{8'hFF}}, 64'd8, 64'h0, 64'd8);
    repeat (9) send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    wait_idle();

    // A zero length acts as one and an oversized replacement length saturates.
    configure(64'hAA, 64'hFFFF_FFFF_FFFF_FFF0, {$urandom, $urandom}, 64'd15);
    send_item(8'hAA, 1'b1);
    send_item(8'h55, 1'b1);
    wait_idle();

    configure({$urandom, $urandom}, 64'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
    send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
    send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);

    phase = 0;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      wait_idle();
      alpha = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < PACK_BYTES; k++)
        pb[8*k +: 8] = alpha ? ($urandom_range(0, 1) ? 8'h41 : 8'h42)
                             : BYTE_W'($urandom_range(0, 255));
      pl = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: pl[LEN_W-1:0] = 4'd0;
        1: pl[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
        2: pl[LEN_W-1:0] = 4'd8;
        3: pl[LEN_W-1:0] = 4'd1;
        default: pl[LEN_W-1:0] = LEN_W'($urandom_range(1, 4));
      endcase
      rl = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0: rl[LEN_W-1:0] = 4'd0;
        1: rl[LEN_W-1:0] = 4'd8;
        2: rl[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
        default: rl[LEN_W-1:0] = LEN_W'($urandom_range(0, 8));
      endcase
      configure(pb, pl, {$urandom, $urandom}, rl);
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        // The output side holds off while bytes keep coming, so the block backs up.
        quiet = 1'b1;
        hold_request = 1'b1;
        send_stream(40, 1'b1, alpha);
      end else begin
        send_stream($urandom_range(10, 40), $urandom_range(0, 4) != 0, alpha);
      end
      phase++;
    end
    quiet = 1'b0;
    wait_idle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[stream_substring_replace] OK");
    end else begin
      $display("[stream_substring_replace] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ssr_pkg.sv
sv/ssr_in_if.sv
sv/ssr_out_if.sv
sv/stream_substring_replace.sv
tb/tb_stream_substring_replace.sv
